// File: rtl/stable_top_k_record_sorter_macros.svh
// Assertion helpers used by the sorter top level.
`ifndef STABLE_TOP_K_RECORD_SORTER_MACROS_SVH
`define STABLE_TOP_K_RECORD_SORTER_MACROS_SVH

// Check a property on every rising edge, masked while reset is low.
`define STKS_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Check a property on every rising edge, reset included.
`define STKS_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/stks_pkg.sv
`default_nettype none

package stks_pkg;

    // Number of records kept per batch.
    localparam int KEEP   = 6;
    // Fill count holds 0..KEEP, read index holds 0..KEEP-1.
    localparam int CNT_W  = $clog2(KEEP + 1);
    localparam int IDX_W  = (KEEP > 1) ? $clog2(KEEP) : 1;
    localparam int RANK_W = 6;

    typedef struct packed {
        logic signed [31:0] key_value;
        logic        [15:0] payload_value;
        logic        [63:0] name_code;
        logic               batch_end;
    } in_t;

    typedef struct packed {
        logic [RANK_W-1:0]  rank_index;
        logic signed [31:0] out_key;
        logic        [15:0] out_payload;
        logic        [63:0] out_name;
        logic               final_result;
    } out_t;

    // Controller to datapath.
    typedef struct packed {
        logic insert;
        logic advance;
        logic clear;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic             rd_last;
        logic [CNT_W-1:0] count;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/stable_top_k_record_sorter.sv
// Stable top-k record sorter.
// Input channel s_valid/s_ready/s_data carries one record per beat: a signed
// key, a payload, a packed name tag and a batch_end mark. The block keeps the
// best KEEP records in descending key order; equal keys stay in arrival order.
// Loading: each beat compares against all kept entries in parallel and
// shifts the list in the same cycle.
// After the beat that carries batch_end, s_ready drops and the kept list
// drains on m_valid/m_ready/m_data, best first, one result per cycle while
// m_ready is high; final_result marks the last one. The first result is
// valid the cycle after the batch_end beat. When the final result is taken
// the list is emptied and s_ready rises again in the next cycle.
// A batch of N records therefore drains min(N, KEEP) results. A stall on
// m_ready holds the current result; no input is taken until the drain
// ends.
// Reset (aresetn low, synchronous) empties the list and returns to loading.
`default_nettype none

module stable_top_k_record_sorter import stks_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

`include "stable_top_k_record_sorter_macros.svh"

    cmd_t    cmd;
    status_t status;

    stks_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_batch_end (s_data.batch_end),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .status      (status),
        .cmd         (cmd)
    );

    stks_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_data  (s_data),
        .out_data (m_data),
        .status   (status)
    );

    // Fill count never passes the list depth.
    `STKS_ASSERT(a_count_bound, aclk, aresetn, status.count <= CNT_W'(KEEP), "count over KEEP")
    // A batch_end beat starts the drain.
    `STKS_ASSERT(a_end_drains, aclk, aresetn, (s_valid && s_ready && s_data.batch_end) |=> m_valid, "no drain after batch end")
    // Taking the final result empties the list.
    `STKS_ASSERT(a_final_clears, aclk, aresetn, (m_valid && m_ready && m_data.final_result) |=> (status.count == '0 && !m_valid), "list not cleared")
    // Never load and drain at once.
    `STKS_ASSERT(a_excl, aclk, aresetn, !(m_valid && s_ready), "load and drain overlap")
    // Reset leaves no result pending.
    `STKS_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (!m_valid && status.count == '0), "reset not idle")

endmodule

`default_nettype wire

// File: rtl/stks_datapath.sv
`default_nettype none

module stks_datapath import stks_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire cmd_t    cmd,
    input  wire in_t     in_data,
    output out_t         out_data,
    output status_t      status
);

    logic signed [31:0] key_reg     [KEEP];
    logic        [15:0] payload_reg [KEEP];
    logic        [63:0] name_reg    [KEEP];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   rd_idx_next;
    logic [KEEP-1:0]    ge;
    logic [KEEP-1:0]    prev_ge;
    logic               rd_last;

    // Flag kept entries that rank at or above the incoming record.
    always_comb begin
        for (int i = 0; i < KEEP; i++) begin
            ge[i] = (CNT_W'(i) < count_reg) &&
                    ($signed(key_reg[i]) >= $signed(in_data.key_value));
        end
        prev_ge[0] = 1'b1;
        for (int i = 1; i < KEEP; i++) begin
            prev_ge[i] = ge[i-1];
        end
    end

    // Insert: keep entries ahead, place the record at the first slot below
    // them, shift the rest down by one; the last entry falls off when full.
    // The head slot never shifts, so its source index is pinned in range.
    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            for (int i = 0; i < KEEP; i++) begin
                if (!ge[i]) begin
                    if (prev_ge[i]) begin
                        key_reg[i]     <= in_data.key_value;
                        payload_reg[i] <= in_data.payload_value;
                        name_reg[i]    <= in_data.name_code;
                    end else begin
                        key_reg[i]     <= key_reg[(i > 0) ? i - 1 : 0];
                        payload_reg[i] <= payload_reg[(i > 0) ? i - 1 : 0];
                        name_reg[i]    <= name_reg[(i > 0) ? i - 1 : 0];
                    end
                end
            end
        end
    end

    // Advance the fill count and the drain index.
    always_comb begin
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        if (cmd.clear) begin
            count_next  = '0;
            rd_idx_next = '0;
        end else begin
            if (cmd.insert && (count_reg != CNT_W'(KEEP))) begin
                count_next = count_reg + CNT_W'(1);
            end
            if (cmd.advance) begin
                rd_idx_next = rd_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            rd_idx_reg <= '0;
        end else begin
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    assign rd_last = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);

    // Present the entry at the drain index.
    assign out_data.rank_index   = RANK_W'(rd_idx_reg);
    assign out_data.out_key      = key_reg[rd_idx_reg];
    assign out_data.out_payload  = payload_reg[rd_idx_reg];
    assign out_data.out_name     = name_reg[rd_idx_reg];
    assign out_data.final_result = rd_last;

    assign status.rd_last = rd_last;
    assign status.count   = count_reg;

endmodule

`default_nettype wire

// File: rtl/stks_ctrl.sv
`default_nettype none

module stks_ctrl import stks_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    input  wire logic    s_batch_end,
    output logic         s_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    localparam logic [0:0] ST_LOAD  = 1'b0;
    localparam logic [0:0] ST_DRAIN = 1'b1;

    logic [0:0] state_reg;
    logic [0:0] state_next;
    logic       s_beat;
    logic       m_beat;

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = (state_reg == ST_DRAIN);
    assign s_beat  = s_valid && s_ready;
    assign m_beat  = m_valid && m_ready;

    // Issue datapath commands.
    assign cmd.insert  = s_beat;
    assign cmd.advance = m_beat;
    assign cmd.clear   = m_beat && status.rd_last;

    // Load records until the batch end, then drain the list.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_beat && s_batch_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (m_beat && status.rd_last) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire
